// ===== rtl/tvd_pkg.sv =====
// Shared constants for the TVD advection row step unit.
`default_nettype none

package tvd_pkg;

    // Default geometry
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int MAX_ROW_CELLS_DEF = 4096;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 23;
    localparam int COURANT_BITS   = 16;
    localparam int EPS_BITS       = 23;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_COURANT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIMITER   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EPSILON   = 2'd3;

    // Limiter codes
    localparam logic [1:0] LIM_MINMOD   = 2'd0;
    localparam logic [1:0] LIM_MC       = 2'd1;
    localparam logic [1:0] LIM_SUPERBEE = 2'd2;
    localparam logic [1:0] LIM_VANLEER  = 2'd3;

    // Register reset values
    localparam logic [COURANT_BITS-1:0] COURANT_RESET = 16'd32768;
    localparam logic [EPS_BITS-1:0]     EPS_RESET     = 23'd1;

endpackage

`default_nettype wire

// ===== rtl/tvd_advection_row_step_unit.sv =====
// Top level: TVD linear-advection row step with selectable flux limiter.
// Sequence: an interior cell with minmod, MC or superbee runs S_DIFF, S_LIM, S_CORR and
//   S_FACE for each of its two faces, then S_DWCALC, S_DWMUL, S_RES and S_EMIT; van Leer
//   adds S_VLMUL, S_DIVGO and S_DIVWAIT per slope for the bit-serial divider (a slope with
//   |a+b| <= epsilon skips its division). Boundary cells go to S_EMIT and give zeros.
// Throughput: one cell at a time; s_tready is high only while the sequencer idles.
// Reset: rst_n clears window, position, pending count and registers to their defaults.
`default_nettype none

module tvd_advection_row_step_unit
    import tvd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int MAX_ROW_CELLS = MAX_ROW_CELLS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // slave: tdata = sample_in
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  wire logic                                s_tlast,
    // master: tdata = sample_out
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,
    output logic                                     m_tlast,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]           cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]            cfg_data
);

    localparam int SW   = SAMPLE_BITS;
    localparam int DBW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PW   = $clog2(MAX_ROW_CELLS + 1);
    localparam int MA   = SW + 3;
    localparam int MB   = (SW + 1 > 17) ? SW + 1 : 17;
    localparam int PRW  = MA + MB;
    localparam int NW   = 2 * SW + 2;
    localparam int DENW = SW + 2;
    localparam int EW   = (SW + 2 > EPS_BITS) ? SW + 2 : EPS_BITS;

    localparam logic [NW-1:0] VCAP = {{(NW-SW-1){1'b0}}, 1'b1, {SW{1'b0}}};
    localparam logic signed [SW+3:0] RMAX = {5'b00000, {(SW-1){1'b1}}};
    localparam logic signed [SW+3:0] RMIN = {5'b11111, {(SW-1){1'b0}}};

    typedef enum logic [3:0]
    {
        S_IDLE, S_DIFF, S_LIM, S_VLMUL, S_DIVGO, S_DIVWAIT,
        S_CORR, S_FACE, S_DWCALC, S_DWMUL, S_RES, S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [COURANT_BITS-1:0] courant_reg;
    logic                    dir_reg;
    logic [1:0]              mode_reg;
    logic [EPS_BITS-1:0]     eps_reg;

    // stencil line: [0] oldest, [4] newest
    logic signed [SW-1:0] h_reg [5];
    logic [PW-1:0]        pos_reg;
    logic [1:0]           pend_reg;

    // datapath registers
    logic                 sel_reg;
    logic signed [SW:0]   a_reg;
    logic signed [SW:0]   b_reg;
    logic [SW:0]          am_reg;
    logic [SW:0]          bm_reg;
    logic [DENW-1:0]      dm_reg;
    logic                 vneg_reg;
    logic [SW:0]          slope_mag_reg;
    logic                 slope_neg_reg;
    logic signed [SW+1:0] face_reg [2];
    logic [SW+2:0]        dw_mag_reg;
    logic                 dw_neg_reg;
    logic [PRW-1:0]       prod_reg;
    logic signed [SW-1:0] res_reg;
    logic [1:0]           left_reg;
    logic                 end_reg;

    // output register
    logic                 m_valid_reg;
    logic signed [SW-1:0] m_data_reg;
    logic                 m_last_reg;

    // stencil taps for the slope being worked on
    logic [2:0]           off;
    logic signed [SW-1:0] t_lo;
    logic signed [SW-1:0] t_mid;
    logic signed [SW-1:0] t_hi;

    always_comb
    begin
        off   = {2'b00, sel_reg} + {2'b00, dir_reg};
        t_lo  = h_reg[off];
        t_mid = h_reg[off + 3'd1];
        t_hi  = h_reg[off + 3'd2];
    end

    // limiter on the slope pair
    logic              a_neg;
    logic              b_neg;
    logic [SW:0]       am;
    logic [SW:0]       bm;
    logic signed [SW+1:0] sum;
    logic [SW+1:0]     smag;
    logic              same_sign;
    logic [SW+1:0]     am2;
    logic [SW+1:0]     bm2;
    logic [SW+1:0]     min_ab;
    logic [SW+1:0]     min_2ab;
    logic [SW+1:0]     sb_x;
    logic [SW+1:0]     sb_y;
    logic [SW+1:0]     lim_mag;
    logic              small_sum;

    always_comb
    begin
        a_neg     = a_reg[SW];
        b_neg     = b_reg[SW];
        am        = a_neg ? (SW+1)'(-a_reg) : a_reg;
        bm        = b_neg ? (SW+1)'(-b_reg) : b_reg;
        sum       = {a_reg[SW], a_reg} + {b_reg[SW], b_reg};
        smag      = sum[SW+1] ? (SW+2)'(-sum) : sum;
        same_sign = (a_neg == b_neg) && (a_reg != '0) && (b_reg != '0);
        am2       = {am, 1'b0};
        bm2       = {bm, 1'b0};
        min_ab    = (am < bm) ? {1'b0, am} : {1'b0, bm};
        min_2ab   = (am2 < bm2) ? am2 : bm2;
        sb_x      = (am2 < {1'b0, bm}) ? am2 : {1'b0, bm};
        sb_y      = ({1'b0, am} < bm2) ? {1'b0, am} : bm2;
        small_sum = EW'(smag) <= EW'(eps_reg);
        case (mode_reg)
            LIM_MINMOD:   lim_mag = min_ab;
            LIM_MC:       lim_mag = ((smag >> 1) < min_2ab) ? (smag >> 1) : min_2ab;
            LIM_SUPERBEE: lim_mag = (sb_x > sb_y) ? sb_x : sb_y;
            default:      lim_mag = '0;
        endcase
        if (!same_sign)
        begin
            lim_mag = '0;
        end
    end

    // shared multiplier operands
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic          mul_en;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (state_reg)
            S_VLMUL:
            begin
                mul_a  = MA'(am_reg);
                mul_b  = MB'(bm_reg);
                mul_en = 1'b1;
            end
            S_CORR:
            begin
                mul_a  = MA'(slope_mag_reg);
                mul_b  = MB'(17'h10000 - {1'b0, courant_reg});
                mul_en = 1'b1;
            end
            S_DWMUL:
            begin
                mul_a  = MA'(dw_mag_reg);
                mul_b  = MB'(courant_reg);
                mul_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // van Leer divider
    logic            div_start;
    logic            div_busy;
    logic            div_done;
    logic [NW-1:0]   div_quo;
    logic [NW-1:0]   div_num;

    assign div_start = (state_reg == S_DIVGO);
    assign div_num   = {prod_reg[2*SW:0], 1'b0};

    tvd_div
    #(
        .NUM_BITS (NW),
        .DEN_BITS (DENW)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dm_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // face, difference and final value
    logic [SW-1:0]        corr_mag;
    logic                 corr_neg;
    logic signed [SW+1:0] face_val;
    logic signed [SW+2:0] dw;
    logic [SW+2:0]        delta;
    logic signed [SW+3:0] res_wide;
    logic signed [SW-1:0] res_sat;
    logic [SW:0]          vl_mag;

    always_comb
    begin
        corr_mag = prod_reg[17 +: SW];
        corr_neg = slope_neg_reg ^ dir_reg;
        face_val = (SW+2)'(t_mid) + (corr_neg ? -(SW+2)'(corr_mag) : (SW+2)'(corr_mag));
        dw       = (SW+3)'(face_reg[1]) - (SW+3)'(face_reg[0]);
        delta    = prod_reg[16 +: SW+3];
        res_wide = (SW+4)'(h_reg[2]) + (dw_neg_reg ? (SW+4)'(delta) : -(SW+4)'(delta));
        if (res_wide > RMAX)
        begin
            res_sat = RMAX[SW-1:0];
        end
        else if (res_wide < RMIN)
        begin
            res_sat = RMIN[SW-1:0];
        end
        else
        begin
            res_sat = res_wide[SW-1:0];
        end
        vl_mag = (div_quo > VCAP) ? VCAP[SW:0] : div_quo[SW:0];
    end

    // input request bookkeeping
    logic          in_acc;
    logic          calc_slot;
    logic          interior;
    logic [1:0]    pend_after;
    logic [1:0]    n_out;
    logic          out_free;
    logic          emit_go;

    always_comb
    begin
        in_acc     = s_tvalid && s_tready;
        calc_slot  = pend_reg[1];
        interior   = calc_slot && (pos_reg >= PW'(4));
        pend_after = calc_slot ? pend_reg : pend_reg + 2'd1;
        n_out      = s_tlast ? {1'b0, calc_slot} + pend_after : {1'b0, calc_slot};
        out_free   = !m_valid_reg || m_tready;
        emit_go    = (state_reg == S_EMIT) && (left_reg != 2'd0) && out_free;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            courant_reg   <= COURANT_RESET;
            dir_reg       <= 1'b0;
            mode_reg      <= LIM_MINMOD;
            eps_reg       <= EPS_RESET;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= '0;
            end
            pos_reg       <= '0;
            pend_reg      <= '0;
            sel_reg       <= 1'b0;
            left_reg      <= '0;
            end_reg       <= 1'b0;
            res_reg       <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COURANT:   courant_reg <= cfg_data[COURANT_BITS-1:0];
                    REG_DIRECTION: dir_reg     <= cfg_data[0];
                    REG_LIMITER:   mode_reg    <= cfg_data[1:0];
                    REG_EPSILON:   eps_reg     <= cfg_data[EPS_BITS-1:0];
                    default:       eps_reg     <= eps_reg;
                endcase
            end

            if (m_valid_reg && m_tready && !emit_go)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            h_reg[i] <= h_reg[i+1];
                        end
                        h_reg[4] <= s_tdata[SW-1:0];
                        res_reg  <= '0;
                        left_reg <= n_out;
                        end_reg  <= s_tlast;
                        sel_reg  <= 1'b0;
                        if (s_tlast)
                        begin
                            pos_reg  <= '0;
                            pend_reg <= '0;
                        end
                        else
                        begin
                            pend_reg <= pend_after;
                            if (pos_reg < PW'(MAX_ROW_CELLS))
                            begin
                                pos_reg <= pos_reg + 1'b1;
                            end
                        end
                        if (interior)
                        begin
                            state_reg <= S_DIFF;
                        end
                        else if (n_out != 2'd0)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end

                S_DIFF:
                begin
                    a_reg     <= (SW+1)'(t_hi) - (SW+1)'(t_mid);
                    b_reg     <= (SW+1)'(t_mid) - (SW+1)'(t_lo);
                    state_reg <= S_LIM;
                end

                S_LIM:
                begin
                    am_reg   <= am;
                    bm_reg   <= bm;
                    dm_reg   <= smag;
                    vneg_reg <= a_neg ^ b_neg ^ sum[SW+1];
                    if (mode_reg == LIM_VANLEER)
                    begin
                        slope_mag_reg <= '0;
                        slope_neg_reg <= 1'b0;
                        state_reg     <= small_sum ? S_CORR : S_VLMUL;
                    end
                    else
                    begin
                        slope_mag_reg <= lim_mag[SW:0];
                        slope_neg_reg <= a_neg;
                        state_reg     <= S_CORR;
                    end
                end

                S_VLMUL:
                begin
                    state_reg <= S_DIVGO;
                end

                S_DIVGO:
                begin
                    state_reg <= S_DIVWAIT;
                end

                S_DIVWAIT:
                begin
                    if (div_done)
                    begin
                        slope_mag_reg <= vl_mag;
                        slope_neg_reg <= vneg_reg;
                        state_reg     <= S_CORR;
                    end
                end

                S_CORR:
                begin
                    state_reg <= S_FACE;
                end

                S_FACE:
                begin
                    face_reg[sel_reg] <= face_val;
                    if (sel_reg)
                    begin
                        state_reg <= S_DWCALC;
                    end
                    else
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_DIFF;
                    end
                end

                S_DWCALC:
                begin
                    dw_neg_reg <= dw[SW+2];
                    dw_mag_reg <= dw[SW+2] ? (SW+3)'(-dw) : dw;
                    state_reg  <= S_DWMUL;
                end

                S_DWMUL:
                begin
                    state_reg <= S_RES;
                end

                S_RES:
                begin
                    res_reg   <= res_sat;
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (left_reg == 2'd0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        m_last_reg  <= end_reg && (left_reg == 2'd1);
                        res_reg     <= '0;
                        left_reg    <= left_reg - 2'd1;
                        if (left_reg == 2'd1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = DBW'($unsigned(m_data_reg));
    assign m_tlast   = m_last_reg;

`ifndef NO_ASSERTIONS
    // pending count never exceeds two cells
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("pending count out of range");

    // end of row clears position and pending count
    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (pos_reg == '0 && pend_reg == '0))
        else $error("row end did not clear position");

    // divider is only started when free
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // a last result is never followed by more results of the same request
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && left_reg == 2'd1) |=> (left_reg == 2'd0))
        else $error("result count mismatch");
`endif

endmodule

`default_nettype wire

// ===== rtl/tvd_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module tvd_div
#(
    parameter int NUM_BITS = 50,
    parameter int DEN_BITS = 26
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     busy,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quo
);

    localparam int CW = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] nq_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   trial;
    logic                fits;
    logic [DEN_BITS:0]   diff;

    // trial remainder with the next numerator bit shifted in
    always_comb
    begin
        trial = {rem_reg, nq_reg[NUM_BITS-1]};
        fits  = trial >= {1'b0, den};
        diff  = trial - {1'b0, den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            nq_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_BITS);
                rem_reg  <= '0;
                nq_reg   <= num;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                nq_reg  <= {nq_reg[NUM_BITS-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the TVD advection row step unit.
`default_nettype none

module testbench;
    import tvd_pkg::*;

    localparam int SB = 24;
    localparam int TW = ((SB + 7) / 8) * 8;
    localparam int ROW_LIMIT = 4096;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SB - 1)) - 1;
    localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (SB - 1));

    typedef struct packed
    {
        logic [SB-1:0] sample;
        logic          done;
    } cell_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [TW-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [TW-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Predictor state and register copies
    logic signed [63:0] win [4];
    int unsigned pos;
    int unsigned pend;
    logic [15:0] courant;
    logic direction;
    logic [1:0] limiter;
    logic [22:0] epsilon;

    cell_result_t expected_cells [$];
    int errors;
    int idle_cycles;
    bit hold_off;
    int hold_count;

    tvd_advection_row_step_unit #(.SAMPLE_BITS(SB), .MAX_ROW_CELLS(ROW_LIMIT)) DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),     // [23:0] sample_in
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),     // [23:0] sample_out
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] mag_of(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    // trunc_toward_zero(a * m / 2^s)
    function automatic logic signed [63:0] fx_scale(logic signed [63:0] a, logic [16:0] m,
                                                     int s);
        logic [127:0] p;
        p = (128'(mag_of(a)) * m) >> s;
        return a < 0 ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic logic signed [63:0] vanleer_slope(logic signed [63:0] a,
                                                          logic signed [63:0] b);
        logic signed [63:0] d;
        logic [127:0] q;
        logic [63:0] qm;
        d = a + b;
        if (mag_of(d) <= 64'(epsilon))
            return 0;
        q = (2 * 128'(mag_of(a)) * 128'(mag_of(b))) / 128'(mag_of(d));
        qm = q > (128'd1 << SB) ? (64'd1 << SB) : q[63:0];
        return ((a < 0) ^ (b < 0) ^ (d < 0)) ? -$signed(qm) : $signed(qm);
    endfunction

    function automatic logic signed [63:0] limited_slope(logic signed [63:0] dn,
                                                          logic signed [63:0] md,
                                                          logic signed [63:0] up);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0] am;
        logic [63:0] bm;
        logic [63:0] m;
        a = up - md;
        b = md - dn;
        am = mag_of(a);
        bm = mag_of(b);
        if (limiter == LIM_VANLEER)
            return vanleer_slope(a, b);
        if (!((a > 0 && b > 0) || (a < 0 && b < 0)))
            return 0;
        case (limiter)
            LIM_MINMOD:   m = am < bm ? am : bm;
            LIM_MC:
            begin
                m = mag_of(a + b) >> 1;
                if (2 * am < m) m = 2 * am;
                if (2 * bm < m) m = 2 * bm;
            end
            default:
            begin
                m = (2 * am < bm) ? 2 * am : bm;
                if (((am < 2 * bm) ? am : 2 * bm) > m)
                    m = (am < 2 * bm) ? am : 2 * bm;
            end
        endcase
        return a < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] face_corr(logic signed [63:0] l);
        return fx_scale(l, 17'd65536 - courant, 17);
    endfunction

    function automatic logic [SB-1:0] next_level(logic signed [63:0] x);
        logic signed [63:0] fi;
        logic signed [63:0] fm;
        logic signed [63:0] r;
        if (!direction)
        begin
            fi = win[2] + face_corr(limited_slope(win[1], win[2], win[3]));
            fm = win[1] + face_corr(limited_slope(win[0], win[1], win[2]));
        end
        else
        begin
            fi = win[3] - face_corr(limited_slope(win[2], win[3], x));
            fm = win[2] - face_corr(limited_slope(win[1], win[2], win[3]));
        end
        r = win[2] - fx_scale(fi - fm, {1'b0, courant}, 16);
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        return r[SB-1:0];
    endfunction

    // Append one expected result
    task automatic expect_result(logic [SB-1:0] v, logic last);
        cell_result_t r;
        r.sample = v;
        r.done = last;
        expected_cells.insert(expected_cells.size(), r);
    endtask

    // Advance the predictor by one accepted cell
    task automatic predict_cell(logic [SB-1:0] raw, logic last);
        logic signed [63:0] x;
        int unsigned k;
        x = 64'($signed(raw));
        k = pos;
        if (pend >= 2)
            expect_result(k >= 4 ? next_level(x) : '0, 1'b0);
        else
            pend++;
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = x;
        if (k < ROW_LIMIT)
            pos = k + 1;
        if (last)
        begin
            repeat (pend) expect_result('0, 1'b0);
            if (expected_cells.size() > 0)
                expected_cells[$].done = 1'b1;
            pos = 0;
            pend = 0;
        end
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (g) @(negedge clk);
    endtask

    // Send one cell request
    task automatic send_cell(logic [SB-1:0] v, logic last);
        s_tdata <= TW'(v);
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_cell(v, last);
        @(negedge clk);
        if ($urandom_range(0, 3) != 0)
        begin
            s_tvalid <= 1'b0;
            random_gap();
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_cells.size() > 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_COURANT:   courant = v[15:0];
            REG_DIRECTION: direction = v[0];
            REG_LIMITER:   limiter = v[1:0];
            default:       epsilon = v[22:0];
        endcase
        @(negedge clk);
    endtask

    task automatic configure(logic [15:0] c, logic d, logic [1:0] l, logic [22:0] e);
        wait_idle();
        write_reg(REG_COURANT, 23'(c));
        write_reg(REG_DIRECTION, 23'(d));
        write_reg(REG_LIMITER, 23'(l));
        write_reg(REG_EPSILON, e);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return SAT_HI[SB-1:0];
            1: return SAT_LO[SB-1:0];
            2: return SB'($signed($urandom_range(0, 200)) - 100);
            default: return SB'($urandom);
        endcase
    endfunction

    // Extremes, short rows and boundary handling
    task automatic test_directed();
        send_cell('0, 1'b1);
        send_cell(SAT_HI[SB-1:0], 1'b0);
        send_cell(SAT_LO[SB-1:0], 1'b1);
        for (int i = 0; i < 4; i++)
            send_cell(SB'(i * 1000), i == 3);
        for (int i = 0; i < 10; i++)
            send_cell(i[0] ? SAT_HI[SB-1:0] : SAT_LO[SB-1:0], i == 9);
        for (int i = 0; i < 6; i++)
            send_cell(SB'(i * i * 4096), i == 5);
    endtask

    // Rows of random length and content with a given setting
    task automatic test_rows(int cells, bit smooth);
        int n;
        logic [SB-1:0] v;
        n = 0;
        v = '0;
        while (n < cells)
        begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 20);
            for (int i = 0; i < len && n < cells; i++)
            begin
                v = smooth ? v + SB'($signed($urandom_range(0, 60000)) - 30000)
                           : rand_sample();
                send_cell(v, (i == len - 1) || (n == cells - 1));
                n++;
            end
        end
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        hold_count = 400;
        hold_off = 1'b1;
        test_rows(12, 1'b0);
    endtask

    // Output side: ready with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
        begin
            m_tready <= 1'b0;
            if (hold_count > 0)
                hold_count <= hold_count - 1;
            else
                hold_off <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end

    // Result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || hold_off)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $error("unexpected result sample_out=%h", m_tdata[SB-1:0]);
                    errors++;
                end
                else
                begin
                    cell_result_t e;
                    e = expected_cells.pop_front();
                    if (m_tdata[SB-1:0] !== e.sample)
                    begin
                        $error("sample_out expected %h actual %h", e.sample, m_tdata[SB-1:0]);
                        errors++;
                    end
                    if (m_tlast !== e.done)
                    begin
                        $error("row_done expected %b actual %b", e.done, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_COURANT;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        hold_count = 0;
        for (int i = 0; i < 4; i++) win[i] = 0;
        pos = 0;
        pend = 0;
        courant = COURANT_RESET;
        direction = 1'b0;
        limiter = LIM_MINMOD;
        epsilon = EPS_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_rows(20, 1'b1);
        configure(16'd0, 1'b1, LIM_MC, 23'd0);
        test_rows(20, 1'b1);
        test_backpressure();
        configure(16'hFFFF, 1'b0, LIM_SUPERBEE, 23'h7FFFFF);
        test_rows(20, 1'b0);
        configure(16'd40000, 1'b1, LIM_VANLEER, 23'd0);
        test_rows(25, 1'b0);
        configure(16'($urandom), 1'b0, LIM_VANLEER, 23'h7FFFFF);
        test_rows(15, 1'b1);
        configure(16'($urandom), 1'b0, LIM_VANLEER, 23'd20000);
        test_rows(25, 1'b1);
        configure(16'($urandom), 1'b1, LIM_MINMOD, 23'($urandom));
        test_rows(25, 1'b0);
        configure(16'($urandom), 1'b0, LIM_MC, 23'd1);
        test_rows(25, 1'b0);
        wait_idle();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/tvd_pkg.sv
rtl/tvd_div.sv
rtl/tvd_advection_row_step_unit.sv
verif/testbench.sv
